### src/mswf_pkg.sv
// ----------------------------------------------------------------------------
// mswf_pkg
// shared types and constants of the best 3x3 window sum finder
// ----------------------------------------------------------------------------
package mswf_pkg;

  localparam int unsigned CELL_W      = 8;   // cell value width
  localparam int unsigned SUM_W       = 12;  // 3x3 block sum width
  localparam int unsigned POS_W       = 4;   // reported row / column width
  localparam int unsigned GRID_W      = 5;   // grid size register width
  localparam int unsigned MIN_SIDE    = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_MAX     = 9 * ((2 ** CELL_W) - 1);

  localparam logic [GRID_W-1:0] GRID_SIZE_RESET = GRID_W'(16);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [GRID_W-1:0] grid_t;
  typedef logic [QCNT_W-1:0] qcnt_t;

  // one raster position as handed from front to back
  typedef struct packed {
    cell_t above2;    // cell two rows up
    cell_t above1;    // cell one row up
    cell_t cur_cell;  // current cell
    logic  is_block;  // window covers a full 3x3 block
    logic  last;      // last cell of the grid
    pos_t  row;       // top row of the block
    pos_t  col;       // left column of the block
  } col_entry_t;

endpackage

### src/mswf_cell_if.sv
// ----------------------------------------------------------------------------
// mswf_cell_if
// input channel: one grid cell per beat
// ----------------------------------------------------------------------------
interface mswf_cell_if;
  import mswf_pkg::*;

  logic  valid;
  logic  ready;
  cell_t cell_value;

  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

### src/mswf_result_if.sv
// ----------------------------------------------------------------------------
// mswf_result_if
// output channel: one best block per grid
// ----------------------------------------------------------------------------
interface mswf_result_if;
  import mswf_pkg::*;

  logic  valid;
  logic  ready;
  sum_t  best_sum;
  pos_t  best_row;
  pos_t  best_col;
  cell_t cell_r0c0;
  cell_t cell_r0c1;
  cell_t cell_r0c2;
  cell_t cell_r1c0;
  cell_t cell_r1c1;
  cell_t cell_r1c2;
  cell_t cell_r2c0;
  cell_t cell_r2c1;
  cell_t cell_r2c2;

  modport source (
    output valid, output best_sum, output best_row, output best_col,
    output cell_r0c0, output cell_r0c1, output cell_r0c2,
    output cell_r1c0, output cell_r1c1, output cell_r1c2,
    output cell_r2c0, output cell_r2c1, output cell_r2c2,
    input  ready
  );
  modport sink (
    input  valid, input best_sum, input best_row, input best_col,
    input  cell_r0c0, input cell_r0c1, input cell_r0c2,
    input  cell_r1c0, input cell_r1c1, input cell_r1c2,
    input  cell_r2c0, input cell_r2c1, input cell_r2c2,
    output ready
  );
endinterface

### src/mswf_ram.sv
// ----------------------------------------------------------------------------
// mswf_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module mswf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### src/mswf_fifo.sv
// ----------------------------------------------------------------------------
// mswf_fifo
// short queue of raster positions between front and back
// ----------------------------------------------------------------------------
module mswf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  mswf_pkg::col_entry_t push_data_i,
  input  logic                pop_i,
  output mswf_pkg::col_entry_t pop_data_o,
  output logic                empty_o,
  output mswf_pkg::qcnt_t     count_o
);
  import mswf_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  col_entry_t       slot_q [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  qcnt_t            count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = slot_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;

endmodule

### src/mswf_front.sv
// ----------------------------------------------------------------------------
// mswf_front
// takes cells, tracks the raster position, runs the two line stores
// ----------------------------------------------------------------------------
module mswf_front #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  mswf_pkg::grid_t      cfg_data_i,
  mswf_cell_if.sink            cell_i,
  input  mswf_pkg::qcnt_t      queue_count_i,
  output logic                 push_o,
  output mswf_pkg::col_entry_t push_data_o
);
  import mswf_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SIDE);
  localparam int unsigned SW = (AW + 1 > GRID_W) ? AW + 1 : GRID_W;

  grid_t          grid_size_q;
  logic [AW-1:0]  col_q, col_d;
  logic [AW-1:0]  row_q, row_d;
  logic [SW-1:0]  gs_ext, side;
  logic           col_end, row_end, beat;

  logic           s1_valid_q;
  logic [AW-1:0]  s1_addr_q;
  cell_t          s1_cell_q;
  logic           s1_block_q, s1_last_q;
  pos_t           s1_row_q, s1_col_q;

  logic [2*CELL_W-1:0] line_rdata;
  logic [2*CELL_W-1:0] line_wdata;

  // side clamped to MIN_SIDE .. MAX_SIDE
  always_comb begin
    gs_ext = SW'(grid_size_q);
    if (gs_ext < SW'(MIN_SIDE)) begin
      side = SW'(MIN_SIDE);
    end else if (gs_ext > SW'(MAX_SIDE)) begin
      side = SW'(MAX_SIDE);
    end else begin
      side = gs_ext;
    end
  end

  assign col_end = (SW'(col_q) + SW'(1)) >= side;
  assign row_end = (SW'(row_q) + SW'(1)) >= side;

  assign cell_i.ready = (queue_count_i + QCNT_W'(s1_valid_q)) < QCNT_W'(QUEUE_DEPTH);
  assign beat         = cell_i.valid && cell_i.ready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (beat) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + AW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RESET;
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        grid_size_q <= cfg_data_i;
      end
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= beat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat) begin
      s1_addr_q  <= col_q;
      s1_cell_q  <= cell_i.cell_value;
      s1_block_q <= (row_q >= AW'(2)) && (col_q >= AW'(2));
      s1_last_q  <= col_end && row_end;
      s1_row_q   <= POS_W'(row_q - AW'(2));
      s1_col_q   <= POS_W'(col_q - AW'(2));
    end
  end

  // upper line in the high half, middle line in the low half
  assign line_wdata = {line_rdata[CELL_W-1:0], s1_cell_q};

  mswf_ram #(
    .WIDTH (2 * CELL_W),
    .DEPTH (MAX_SIDE)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (line_wdata),
    .raddr_i (col_q),
    .rdata_o (line_rdata)
  );

  assign push_o               = s1_valid_q;
  assign push_data_o.above2   = line_rdata[2*CELL_W-1:CELL_W];
  assign push_data_o.above1   = line_rdata[CELL_W-1:0];
  assign push_data_o.cur_cell = s1_cell_q;
  assign push_data_o.is_block = s1_block_q;
  assign push_data_o.last     = s1_last_q;
  assign push_data_o.row      = s1_row_q;
  assign push_data_o.col      = s1_col_q;

endmodule

### src/mswf_back.sv
// ----------------------------------------------------------------------------
// mswf_back
// 3x3 window, block sum, best block tracking and result register
// ----------------------------------------------------------------------------
module mswf_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  mswf_pkg::col_entry_t entry_i,
  output logic                 pop_o,
  mswf_result_if.source        result_o
);
  import mswf_pkg::*;

  cell_t win_q [9];
  cell_t win_d [9];
  sum_t  row_sum [3];
  sum_t  win_sum;

  logic  sb_valid_q;
  sum_t  sb_sum_q;
  cell_t sb_win_q [9];
  logic  sb_block_q, sb_last_q;
  pos_t  sb_row_q, sb_col_q;

  logic  have_best_q;
  sum_t  top_sum_q;
  pos_t  top_row_q, top_col_q;
  cell_t top_blk_q [9];

  logic  out_valid_q;
  sum_t  out_sum_q;
  pos_t  out_row_q, out_col_q;
  cell_t out_blk_q [9];

  logic  go, fire, better;

  // shift the window left by one column, new column enters on the right
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]     = win_q[k*3+1];
      win_d[k*3 + 1] = win_q[k*3+2];
    end
    win_d[2] = entry_i.above2;
    win_d[5] = entry_i.above1;
    win_d[8] = entry_i.cur_cell;
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = SUM_W'(win_d[k*3]) + SUM_W'(win_d[k*3+1]) + SUM_W'(win_d[k*3+2]);
    end
    win_sum = row_sum[0] + row_sum[1] + row_sum[2];
  end

  // a last beat needs a free result slot
  assign go     = !sb_valid_q || !sb_last_q || !out_valid_q || result_o.ready;
  assign pop_o  = !empty_i && go;
  assign fire   = sb_valid_q && go;
  assign better = sb_block_q && (!have_best_q || (sb_sum_q > top_sum_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sb_valid_q  <= 1'b0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        sb_valid_q <= 1'b1;
      end else if (go) begin
        sb_valid_q <= 1'b0;
      end
      if (fire && sb_last_q) begin
        have_best_q <= 1'b0;
      end else if (fire && better) begin
        have_best_q <= 1'b1;
      end
      if (fire && sb_last_q) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      win_q      <= win_d;
      sb_win_q   <= win_d;
      sb_sum_q   <= win_sum;
      sb_block_q <= entry_i.is_block;
      sb_last_q  <= entry_i.last;
      sb_row_q   <= entry_i.row;
      sb_col_q   <= entry_i.col;
    end
    if (fire && better) begin
      top_sum_q <= sb_sum_q;
      top_row_q <= sb_row_q;
      top_col_q <= sb_col_q;
      top_blk_q <= sb_win_q;
    end
    if (fire && sb_last_q) begin
      if (better) begin
        out_sum_q <= sb_sum_q;
        out_row_q <= sb_row_q;
        out_col_q <= sb_col_q;
        out_blk_q <= sb_win_q;
      end else begin
        out_sum_q <= top_sum_q;
        out_row_q <= top_row_q;
        out_col_q <= top_col_q;
        out_blk_q <= top_blk_q;
      end
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.best_sum  = out_sum_q;
  assign result_o.best_row  = out_row_q;
  assign result_o.best_col  = out_col_q;
  assign result_o.cell_r0c0 = out_blk_q[0];
  assign result_o.cell_r0c1 = out_blk_q[1];
  assign result_o.cell_r0c2 = out_blk_q[2];
  assign result_o.cell_r1c0 = out_blk_q[3];
  assign result_o.cell_r1c1 = out_blk_q[4];
  assign result_o.cell_r1c2 = out_blk_q[5];
  assign result_o.cell_r2c0 = out_blk_q[6];
  assign result_o.cell_r2c1 = out_blk_q[7];
  assign result_o.cell_r2c2 = out_blk_q[8];

endmodule

### src/max_3x3_window_sum_finder.sv
// ----------------------------------------------------------------------------
// max_3x3_window_sum_finder
// finds the 3x3 block with the largest sum in a raster stream of grid cells
// ----------------------------------------------------------------------------
//
//  channel    dir  handshake      payload
//  ---------  ---  -------------  ----------------------------------------
//  cell_i     in   valid / ready  cell_value, row-major, one cell a beat
//  result_o   out  valid / ready  best_sum, best_row, best_col, nine cells
//  cfg        in   cfg_we_i       cfg_data_i = grid side (3 .. MAX_SIDE)
//
//  one cell beat a cycle sustained while result_o is not stalled; the line
//  store ram (one read, one write port) is touched once per cell and the
//  window adds one column per beat; after the beat with the grid's last
//  cell the result passes the front stage, the queue and the back stage
//  into the result register; reset clears position, queue and result
//  state; no clearing pass runs, cells read from the line stores before
//  they are written never reach a reported block; a stalled result holds
//  the back end; the queue then fills and cell_i drops ready
//
module max_3x3_window_sum_finder #(
  parameter int unsigned MAX_SIDE = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  mswf_pkg::grid_t   cfg_data_i,
  mswf_cell_if.sink         cell_i,
  mswf_result_if.source     result_o
);
  import mswf_pkg::*;

  // front to queue
  logic       fifo_push;
  col_entry_t fifo_wdata;
  // queue to back
  logic       fifo_pop;
  logic       fifo_empty;
  col_entry_t fifo_rdata;
  qcnt_t      fifo_count;

  logic       cell_beat;

  assign cell_beat = cell_i.valid && cell_i.ready;

  // front: position counters, grid size register, line stores
  mswf_front #(
    .MAX_SIDE (MAX_SIDE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .cell_i        (cell_i),
    .queue_count_i (fifo_count),
    .push_o        (fifo_push),
    .push_data_o   (fifo_wdata)
  );

  // decoupling queue, front reserves a slot before it takes a beat
  mswf_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (fifo_push),
    .push_data_i (fifo_wdata),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_rdata),
    .empty_o     (fifo_empty),
    .count_o     (fifo_count)
  );

  // back: window, block sum, best tracking, result register
  mswf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (fifo_empty),
    .entry_i  (fifo_rdata),
    .pop_o    (fifo_pop),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  // every accepted cell reaches the queue in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_beat |=> fifo_push)
    else $error("accepted cell did not reach the queue");

  // the slot reservation keeps the queue from overflowing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> (fifo_count < QCNT_W'(QUEUE_DEPTH)) || fifo_pop)
    else $error("queue push while full");

  // back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> (fifo_count != '0))
    else $error("queue pop while empty");

  // a reported block sum never exceeds nine full-scale cells
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.best_sum <= SUM_W'(SUM_MAX)))
    else $error("best sum out of range");
`endif

endmodule
